// ----- hdl/bitplane_to_palette_pixel_defines.svh -----
// Assertion macros shared by the bit-plane to palette pixel block.
// Needs no other file; the checks expand to nothing when SYNTHESIS is defined.
`ifndef BITPLANE_TO_PALETTE_PIXEL_DEFINES_SVH
`define BITPLANE_TO_PALETTE_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define B2P_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("b2p: assertion failed");
// An implication that must hold at every clock edge outside reset.
`define B2P_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b2p: implication failed");
`else
`define B2P_ASSERT(lbl, prop)
`define B2P_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- hdl/b2p_pkg.sv -----
// Types, constants and the index remap function of the bit-plane to palette block.
// Used by every module of the block; depends on nothing.
package b2p_pkg;

   localparam int PLANE_W       = 16;
   localparam int PIX_PER_WORD  = 16;
   localparam int PIX_SHIFT     = 4;
   localparam int PLANES_STORED = 7;
   localparam int GROUP_W       = 7;
   localparam int WIDTH_W       = 11;
   localparam int COLUMN_W      = 10;
   localparam int LEVEL_W       = 16;
   localparam int CHAN_W        = 8;
   localparam int INDEX_W       = 8;
   localparam int RESET_WIDTH   = 320;

   // Level scaling: (255 * min(n, 1000) + 500) / 1000 by reciprocal multiply.
   localparam int LEVEL_FULL    = 1000;
   localparam int LEVEL_ROUND   = 500;
   localparam int TERM_W        = 18;
   localparam int SCALE_RECIP   = 268436;
   localparam int SCALE_SHIFT   = 28;
   localparam int PROD_W        = 37;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_EIGHT_BIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LAYOUT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd2;

   // Request operation codes.
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PLANE   = 1'b1;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] pal_index;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic [PLANE_W-1:0] plane_word;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [COLUMN_W-1:0] column;
      logic                row_end;
      logic                run_last;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [INDEX_W-1:0]    index;
      logic [3*CHAN_W-1:0]   rgb;
   } pal_wr_type;

   typedef struct packed {
      logic [PLANES_STORED-1:0][PLANE_W-1:0] planes;
      logic [PLANE_W-1:0]                    word;
      logic [GROUP_W-1:0]                    group;
      logic [WIDTH_W-1:0]                    width;
      logic                                  eight;
   } group_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic                row_end;
      logic                run_last;
   } pix_meta_type;

   // Fixed remap from the raw plane index to the palette entry.
   function automatic logic [INDEX_W-1:0] remap_index(input logic [INDEX_W-1:0] v,
                                                      input logic eight);
      logic [INDEX_W-1:0] r;
      unique case (v)
         8'd1:   r = 8'd2;
         8'd2:   r = 8'd3;
         8'd3:   r = 8'd6;
         8'd5:   r = 8'd7;
         8'd6:   r = 8'd5;
         8'd7:   r = 8'd8;
         8'd8:   r = 8'd9;
         8'd9:   r = 8'd10;
         8'd10:  r = 8'd11;
         8'd11:  r = 8'd14;
         8'd13:  r = 8'd15;
         8'd14:  r = 8'd13;
         8'd15:  r = eight ? 8'd255 : 8'd1;
         8'd255: r = 8'd1;
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/b2p_front.sv -----
// Request front end: configuration registers, plane position counters, plane word
// store, group staging and palette level scaling. Depends on b2p_pkg.
module b2p_front import b2p_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   input  logic                   exp_busy,
   input  logic                   grp_take,
   output logic                   grp_valid,
   output group_type              grp,
   output pal_wr_type             pal_wr
);

   localparam int GROUPS_MAX = (MAX_WIDTH + PIX_PER_WORD - 1) / PIX_PER_WORD;
   localparam int GW         = (GROUPS_MAX > 1) ? $clog2(GROUPS_MAX) : 1;

   logic               eight_ff;
   logic               layout_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [2:0]         plane_ff, plane_in;
   logic [GW-1:0]      group_ff, group_in;

   logic [WIDTH_W-1:0] eff_width;
   logic [7:0]         groups;
   logic [2:0]         last_plane;
   logic               wrap;
   logic [2:0]         p_cur;
   logic [GW-1:0]      g_cur;
   logic               is_last;
   logic [8:0]         g_inc;
   logic               g_wrap;
   logic [GW-1:0]      g_next;
   logic               cfg_hit;
   logic               accept;
   logic               plane_we;
   logic               plane_re;

   logic [PLANES_STORED-1:0][PLANE_W-1:0] plane_rd;

   logic               s1_vld_ff;
   logic [PLANE_W-1:0] s1_word_ff;
   logic [GROUP_W-1:0] s1_group_ff;
   logic [WIDTH_W-1:0] s1_width_ff;
   logic               s1_eight_ff;

   logic               pw_vld_ff;
   logic [INDEX_W-1:0] pw_index_ff;
   logic [TERM_W-1:0]  pw_red_ff, pw_green_ff, pw_blue_ff;

   // Level in thousandths to the dividend 255 * min(n, 1000) + 500.
   function automatic logic [TERM_W-1:0] level_term(input logic [LEVEL_W-1:0] n);
      logic [9:0] nc;
      nc = (n >= LEVEL_W'(LEVEL_FULL)) ? 10'(LEVEL_FULL) : n[9:0];
      return {nc, 8'b0} - TERM_W'(nc) + TERM_W'(LEVEL_ROUND);
   endfunction

   // Division by 1000 through the reciprocal; exact for every dividend used here.
   function automatic logic [CHAN_W-1:0] scale_div(input logic [TERM_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(SCALE_RECIP);
      return prod[SCALE_SHIFT+CHAN_W-1:SCALE_SHIFT];
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         eight_ff  <= 1'b1;
         layout_ff <= 1'b0;
         width_ff  <= WIDTH_W'(RESET_WIDTH);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EIGHT_BIT:   eight_ff  <= csr_wdata[0];
            CSR_LINE_LAYOUT: layout_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH: width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg_hit = csr_we && ((csr_index == CSR_EIGHT_BIT) ||
                               (csr_index == CSR_LINE_LAYOUT) ||
                               (csr_index == CSR_IMAGE_WIDTH));

   // Effective width and the number of 16-pixel groups in a row.
   always_comb begin
      eff_width = width_ff;
      if (width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = WIDTH_W'(MAX_WIDTH);
      end
   end

   assign groups     = 8'((12'(eff_width) + 12'(PIX_PER_WORD - 1)) >> PIX_SHIFT);
   assign last_plane = eight_ff ? 3'd7 : 3'd3;

   // Current position; an out-of-range position restarts at the first word.
   assign wrap    = (plane_ff > last_plane) || (9'(group_ff) >= 9'(groups));
   assign p_cur   = wrap ? '0 : plane_ff;
   assign g_cur   = wrap ? '0 : group_ff;
   assign is_last = (p_cur == last_plane);
   assign g_inc   = 9'(g_cur) + 9'd1;
   assign g_wrap  = (g_inc >= 9'(groups));
   assign g_next  = g_wrap ? '0 : GW'(g_inc);

   // A last-plane word needs the staging register; a palette write waits until
   // every earlier pixel has read the palette.
   always_comb begin
      if (req_data.op == OP_PALETTE) begin
         req_ready = !s1_vld_ff && !exp_busy;
      end else begin
         req_ready = !is_last || !s1_vld_ff || grp_take;
      end
   end

   assign accept   = req_valid && req_ready;
   assign plane_we = accept && (req_data.op == OP_PLANE) && !is_last;
   assign plane_re = accept && (req_data.op == OP_PLANE) && is_last;

   // Next plane and group position.
   always_comb begin
      plane_in = plane_ff;
      group_in = group_ff;
      if (cfg_hit) begin
         plane_in = '0;
         group_in = '0;
      end else if (accept && (req_data.op == OP_PLANE)) begin
         if (!layout_ff) begin
            if (!is_last) begin
               plane_in = p_cur + 3'd1;
               group_in = g_cur;
            end else begin
               plane_in = '0;
               group_in = g_next;
            end
         end else begin
            group_in = g_next;
            if (g_wrap) begin
               plane_in = is_last ? 3'd0 : p_cur + 3'd1;
            end else begin
               plane_in = p_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         group_ff <= '0;
      end else begin
         plane_ff <= plane_in;
         group_ff <= group_in;
      end
   end

   // One word store per stored plane, addressed by group.
   for (genvar pl = 0; pl < PLANES_STORED; pl++) begin : g_plane
      logic [PLANE_W-1:0] ram [GROUPS_MAX];
      logic [PLANE_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (plane_we && (p_cur == 3'(pl))) begin
            ram[g_cur] <= req_data.plane_word;
         end
         if (plane_re) begin
            rd_ff <= ram[g_cur];
         end
      end

      assign plane_rd[pl] = rd_ff;
   end

   // Staging register for a completed group.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (plane_re) begin
         s1_vld_ff <= 1'b1;
      end else if (grp_take) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (plane_re) begin
         s1_word_ff  <= req_data.plane_word;
         s1_group_ff <= GROUP_W'(g_cur);
         s1_width_ff <= eff_width;
         s1_eight_ff <= eight_ff;
      end
   end

   assign grp_valid  = s1_vld_ff;
   assign grp.planes = plane_rd;
   assign grp.word   = s1_word_ff;
   assign grp.group  = s1_group_ff;
   assign grp.width  = s1_width_ff;
   assign grp.eight  = s1_eight_ff;

   // Palette write: dividends registered, then one reciprocal multiply per channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         pw_vld_ff <= 1'b0;
      end else begin
         pw_vld_ff <= accept && (req_data.op == OP_PALETTE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_data.op == OP_PALETTE)) begin
         pw_index_ff <= req_data.pal_index;
         pw_red_ff   <= level_term(req_data.red_level);
         pw_green_ff <= level_term(req_data.green_level);
         pw_blue_ff  <= level_term(req_data.blue_level);
      end
   end

   assign pal_wr.en    = pw_vld_ff;
   assign pal_wr.index = pw_index_ff;
   assign pal_wr.rgb   = {scale_div(pw_red_ff), scale_div(pw_green_ff), scale_div(pw_blue_ff)};

endmodule

// ----- hdl/b2p_expand.sv -----
// Group expander: walks a staged group's pixels up to the row end, builds and
// remaps each index; one palette lookup per ready cycle. Depends on b2p_pkg.
`include "bitplane_to_palette_pixel_defines.svh"
module b2p_expand import b2p_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_valid,
   input  group_type          grp,
   output logic               grp_take,
   output logic               busy,
   input  logic               issue_ready,
   output logic               issue,
   output logic [INDEX_W-1:0] pal_idx,
   output pix_meta_type       meta
);

   logic                           busy_ff;
   group_type                      grp_ff;
   logic [PIX_SHIFT-1:0]           k_ff;
   logic [PIX_SHIFT-1:0]           sel;
   logic [GROUP_W+PIX_SHIFT-1:0]   col;
   logic [PLANES_STORED-1:0]       pb;
   logic                           wb;
   logic [INDEX_W-1:0]             raw_idx;
   logic                           run_last;

   // Column of the current pixel and its place in the row.
   assign col      = {grp_ff.group, k_ff};
   assign run_last = (k_ff == PIX_SHIFT'(PIX_PER_WORD - 1)) ||
                     ((12'(col) + 12'd1) == 12'(grp_ff.width));

   // Plane bits of the current pixel, leftmost pixel in the top bit.
   assign sel = PIX_SHIFT'(PIX_PER_WORD - 1) - k_ff;

   always_comb begin
      for (int pl = 0; pl < PLANES_STORED; pl++) begin
         pb[pl] = grp_ff.planes[pl][sel];
      end
   end

   assign wb      = grp_ff.word[sel];
   assign raw_idx = grp_ff.eight ? {wb, pb} : {4'b0, wb, pb[2:0]};
   assign pal_idx = remap_index(raw_idx, grp_ff.eight);

   assign meta.column   = COLUMN_W'(col);
   assign meta.row_end  = (col == (grp_ff.width - WIDTH_W'(1)));
   assign meta.run_last = run_last;

   // Lookup issue and group hand-over on the final pixel.
   assign issue    = busy_ff && issue_ready;
   assign grp_take = grp_valid && (!busy_ff || (issue && run_last));
   assign busy     = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else if (grp_take) begin
         busy_ff <= 1'b1;
         k_ff    <= '0;
      end else if (issue) begin
         if (run_last) begin
            busy_ff <= 1'b0;
         end else begin
            k_ff <= k_ff + PIX_SHIFT'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_take) begin
         grp_ff <= grp;
      end
   end

   // Every pixel walked lies inside the row.
   `B2P_ASSERT_IMP(a_col_in_row, busy_ff, col < grp_ff.width)
   // A lookup that is not the group's last moves on to the next pixel.
   `B2P_ASSERT(a_step_next, issue && !run_last |=> busy_ff && (k_ff == $past(k_ff) + 4'd1))
   // A newly taken group starts at its leftmost pixel.
   `B2P_ASSERT(a_take_start, grp_take |=> busy_ff && (k_ff == '0))

endmodule

// ----- hdl/b2p_palette.sv -----
// Palette store with per-entry valid bits and a registered lookup stage.
// Depends on b2p_pkg.
module b2p_palette import b2p_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  pal_wr_type         pal_wr,
   input  logic               rd_en,
   input  logic               adv,
   input  logic [INDEX_W-1:0] rd_idx,
   input  pix_meta_type       rd_meta,
   output logic               out_valid,
   output rsp_type            out_data
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [3*CHAN_W-1:0]       ram [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [3*CHAN_W-1:0]       rd_ff;
   logic                      hit_ff;
   logic                      p_vld_ff;
   pix_meta_type              meta_ff;
   logic                      wr_hit;
   logic                      rd_in_range;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic [3*CHAN_W-1:0]       rgb;

   assign wr_hit      = pal_wr.en && (9'(pal_wr.index) < 9'(PALETTE_ENTRIES));
   assign rd_in_range = (9'(rd_idx) < 9'(PALETTE_ENTRIES));
   assign wr_addr     = pal_wr.index[AW-1:0];
   assign rd_addr     = rd_idx[AW-1:0];

   // Entry storage and registered read.
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         ram[wr_addr] <= pal_wr.rgb;
      end
      if (rd_en) begin
         rd_ff   <= ram[rd_addr];
         meta_ff <= rd_meta;
      end
   end

   // Valid bits: an entry never written reads as black.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_hit) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff <= rd_in_range && valid_ff[rd_addr];
      end
   end

   // Lookup stage occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= rd_en;
      end
   end

   assign rgb               = hit_ff ? rd_ff : '0;
   assign out_valid         = p_vld_ff;
   assign out_data.red      = rgb[3*CHAN_W-1:2*CHAN_W];
   assign out_data.green    = rgb[2*CHAN_W-1:CHAN_W];
   assign out_data.blue     = rgb[CHAN_W-1:0];
   assign out_data.column   = meta_ff.column;
   assign out_data.row_end  = meta_ff.row_end;
   assign out_data.run_last = meta_ff.run_last;

endmodule

// ----- hdl/bitplane_to_palette_pixel.sv -----
// Top level of the bit-plane to palette pixel converter.
// Depends on b2p_pkg, b2p_front, b2p_expand and b2p_palette.
//
// Usage:
//   Requests arrive on req_valid/req_ready/req_data. A request with op low writes
//   one palette entry; with op high it delivers one 16-bit plane word. Pixels
//   leave the output register on rsp_valid/rsp_ready/rsp_data, one per ready cycle.
//   Configuration is written through csr_we/csr_index/csr_wdata while idle; any
//   write to a defined register restarts the plane and group position.
// Group flow:
//   The word of the last plane completes a group; its first pixel passes the staging
//   register, walker, lookup stage and output register to rsp; the rest follow one
//   per ready cycle. The pixel walker sets the pace over the sixteen pixels of a group,
//   which holds four plane words with four planes and eight with eight. Earlier plane
//   words are taken every cycle. A palette write is held until every pending pixel has
//   read the palette, and a last-plane word waits while the staging register is full.
// Reset and stalls:
//   Reset clears the palette through its valid bits, with no clearing pass, and
//   sets the registers to eight planes, interleaved words and a width of 320. A
//   low rsp_ready holds the output and lookup stages and the walker; requests back
//   up once the staging register is full.
module bitplane_to_palette_pixel import b2p_pkg::*; #(
   parameter int MAX_WIDTH       = 1024,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   logic               exp_busy;
   logic               grp_take;
   logic               grp_valid;
   group_type          grp;
   pal_wr_type         pal_wr;
   logic               issue;
   logic [INDEX_W-1:0] pal_idx;
   pix_meta_type       meta;
   logic               p_valid;
   rsp_type            p_data;
   logic               o_vld_ff;
   rsp_type            o_data_ff;
   logic               o_take;
   logic               p_adv;

   b2p_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .exp_busy  (exp_busy),
      .grp_take  (grp_take),
      .grp_valid (grp_valid),
      .grp       (grp),
      .pal_wr    (pal_wr)
   );

   b2p_expand u_expand (
      .clock       (clock),
      .reset       (reset),
      .grp_valid   (grp_valid),
      .grp         (grp),
      .grp_take    (grp_take),
      .busy        (exp_busy),
      .issue_ready (p_adv),
      .issue       (issue),
      .pal_idx     (pal_idx),
      .meta        (meta)
   );

   b2p_palette #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_palette (
      .clock     (clock),
      .reset     (reset),
      .pal_wr    (pal_wr),
      .rd_en     (issue),
      .adv       (p_adv),
      .rd_idx    (pal_idx),
      .rd_meta   (meta),
      .out_valid (p_valid),
      .out_data  (p_data)
   );

   // Stall chain: the output register frees, then the lookup stage moves.
   assign o_take = !o_vld_ff || rsp_ready;
   assign p_adv  = !p_valid || o_take;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (o_take) begin
         o_vld_ff <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (o_take) begin
         o_data_ff <= p_data;
      end
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_data  = o_data_ff;

endmodule
